// ===== rtl/core/mmdu_pkg.sv =====
// Shared constants, codes and types of the modular multiply/divide unit.
`timescale 1ns / 1ps

package mmdu_pkg;

   // Datapath width; port fields stay at PORT_BITS and use the low WORD_BITS bits
   localparam int WORD_BITS     = 32;
   localparam int PORT_BITS     = 32;
   localparam int DBL_BITS      = 2 * WORD_BITS;
   localparam int STEP_BITS     = $clog2(DBL_BITS + 1);
   localparam int MODULUS_RESET = 2;

   // Operation codes
   localparam logic [1:0] MODE_MUL = 2'd0;
   localparam logic [1:0] MODE_DIV = 2'd1;
   localparam logic [1:0] MODE_RED = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_NOINV = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_DIV_WAIT,
      S_CMUL,
      S_CRED,
      S_CRED_WAIT,
      S_FMUL,
      S_FRED,
      S_FRED_WAIT,
      S_DONE
   } seq_state_type;

   // Request to the shared shift-subtract divider
   typedef struct packed {
      logic                  start;
      logic                  long_op;   // full double-width dividend
      logic [DBL_BITS-1:0]   dividend;
      logic [WORD_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [WORD_BITS-1:0]  quotient;
      logic [WORD_BITS-1:0]  remainder;
   } div_rsp_type;

   // One incoming word, trimmed to the datapath width
   typedef struct packed {
      logic [1:0]            mode;
      logic [WORD_BITS-1:0]  a;
      logic [WORD_BITS-1:0]  b;
   } item_type;

   typedef struct packed {
      logic                  valid;
      logic [WORD_BITS-1:0]  result;
      logic [1:0]            status;
   } result_type;

endpackage

// ===== rtl/core/mmdu_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mmdu_divider import mmdu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [STEP_BITS-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] dsr_ff, dsr_in;
   logic [DBL_BITS-1:0]  dvd_ff, dvd_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS:0]   diff;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, dvd_ff[DBL_BITS-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   // Load on start, then one step per cycle until the count runs out
   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      dvd_in   = dvd_ff;
      if (div_req.start) begin
         rem_in = '0;
         dsr_in = div_req.divisor;
         if (div_req.long_op) begin
            dvd_in   = div_req.dividend;
            count_in = STEP_BITS'(DBL_BITS);
         end else begin
            dvd_in   = {div_req.dividend[WORD_BITS-1:0], {WORD_BITS{1'b0}}};
            count_in = STEP_BITS'(WORD_BITS);
         end
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == STEP_BITS'(1));
         if (!diff[WORD_BITS]) begin
            rem_in = diff[WORD_BITS-1:0];
            dvd_in = {dvd_ff[DBL_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[WORD_BITS-1:0];
            dvd_in = {dvd_ff[DBL_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
   end

   always_comb begin
      div_rsp.done      = done_ff;
      div_rsp.quotient  = dvd_ff[WORD_BITS-1:0];
      div_rsp.remainder = rem_ff;
   end

endmodule

// ===== rtl/core/mmdu_sequencer.sv =====
// Sequencer: operation flow, extended Euclid state and the shared multiplier.
`timescale 1ns / 1ps

module mmdu_sequencer import mmdu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  item_type             item,
   input  logic [WORD_BITS-1:0] modulus,
   output logic                 idle,
   output result_type           res,
   input  logic                 res_taken,
   output div_req_type          div_req,
   input  div_rsp_type          div_rsp
);

   seq_state_type state_ff, state_in;

   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] x_ff, x_in;       // previous remainder
   logic [WORD_BITS-1:0] y_ff, y_in;       // current remainder
   logic [WORD_BITS-1:0] cur_ff, cur_in;   // coefficient; multiplicand of final product
   logic [WORD_BITS-1:0] prev_ff, prev_in;
   logic [WORD_BITS-1:0] q_ff, q_in;
   logic [DBL_BITS-1:0]  prod_ff, prod_in;
   logic [WORD_BITS-1:0] result_ff, result_in;
   logic [1:0]           status_ff, status_in;

   logic [WORD_BITS-1:0] mul_lhs;
   logic [DBL_BITS-1:0]  product;
   logic [WORD_BITS:0]   coef_sum;
   logic [WORD_BITS:0]   coef_fold;

   // Shared multiplier: q * cur in the Euclid round, a * cur otherwise
   always_comb begin
      mul_lhs = (state_ff == S_CMUL) ? q_ff : a_ff;
      product = DBL_BITS'(mul_lhs) * DBL_BITS'(cur_ff);
   end

   // Next coefficient: (prev + m - (cur*q mod m)) mod m, sum stays below 2m
   always_comb begin
      coef_sum  = {1'b0, prev_ff} + {1'b0, modulus} - {1'b0, div_rsp.remainder};
      coef_fold = (coef_sum >= {1'b0, modulus}) ? coef_sum - {1'b0, modulus} : coef_sum;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (modulus == '0) begin
                  state_in = S_DONE;
               end else begin
                  case (item.mode)
                     MODE_MUL: state_in = S_FMUL;
                     MODE_DIV: begin
                        if (item.b == '0 || modulus == WORD_BITS'(1)) begin
                           state_in = S_DONE;
                        end else begin
                           state_in = S_DIV;
                        end
                     end
                     default:  state_in = S_FRED;
                  endcase
               end
            end
         end
         S_DIV:      state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0) begin
                  state_in = S_CMUL;
               end else if (y_ff == WORD_BITS'(1)) begin
                  state_in = S_FMUL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_CMUL:      state_in = S_CRED;
         S_CRED:      state_in = S_CRED_WAIT;
         S_CRED_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_DIV;
            end
         end
         S_FMUL:      state_in = S_FRED;
         S_FRED:      state_in = S_FRED_WAIT;
         S_FRED_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath register updates
   always_comb begin
      a_in      = a_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      q_in      = q_ff;
      prod_in   = prod_ff;
      result_in = result_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: begin
            a_in      = item.a;
            x_in      = modulus;
            y_in      = item.b;
            cur_in    = (item.mode == MODE_DIV) ? WORD_BITS'(1) : item.b;
            prev_in   = '0;
            prod_in   = DBL_BITS'(item.a);
            result_in = '0;
            if (modulus == '0 || (item.mode == MODE_DIV && item.b == '0)) begin
               status_in = STATUS_ZERO;
            end else begin
               status_in = STATUS_OK;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               q_in = div_rsp.quotient;
               x_in = y_ff;
               y_in = div_rsp.remainder;
               // last nonzero remainder is the gcd; inverse sits in cur
               if (div_rsp.remainder == '0 && y_ff != WORD_BITS'(1)) begin
                  status_in = STATUS_NOINV;
               end
            end
         end
         S_CMUL, S_FMUL: begin
            prod_in = product;
         end
         S_CRED_WAIT: begin
            if (div_rsp.done) begin
               prev_in = cur_ff;
               cur_in  = coef_fold[WORD_BITS-1:0];
            end
         end
         S_FRED_WAIT: begin
            if (div_rsp.done) begin
               result_in = div_rsp.remainder;
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs
   always_comb begin
      idle            = (state_ff == S_IDLE);
      div_req.start   = (state_ff == S_DIV) || (state_ff == S_CRED) || (state_ff == S_FRED);
      div_req.long_op = (state_ff != S_DIV);
      div_req.dividend = (state_ff == S_DIV) ? DBL_BITS'(x_ff) : prod_ff;
      div_req.divisor  = (state_ff == S_DIV) ? y_ff : modulus;
      res.valid  = (state_ff == S_DONE);
      res.result = result_ff;
      res.status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      q_ff      <= q_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

endmodule

// ===== rtl/core/modular_multiply_divide_unit.sv =====
// Top level: modulus register, request intake, result output register.
`timescale 1ns / 1ps

// Modular arithmetic unit over the modulus in the CSR (reset value 2). Mode 0
// returns a*b mod m, mode 1 returns a*inverse(b) mod m via extended Euclid,
// modes 2 and 3 return a mod m. Status 1 flags a zero modulus or, in mode 1, a
// zero divisor; status 2 flags a divisor sharing a factor with m. The result is
// zero whenever status is nonzero. One word is worked on at a time and
// req_stall stays high until its result moves to the output register. All
// arithmetic runs on one restoring divider producing one quotient bit per
// cycle: mode 0 needs a multiply and a double-width reduction, modes 2 and 3
// only the reduction; mode 1 adds, per Euclid round, a single-width divide plus
// a double-width reduction of the coefficient product, up to about 46 rounds
// for a 32-bit modulus, and far fewer rounds for typical operands.
module modular_multiply_divide_unit import mmdu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [PORT_BITS-1:0] csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [PORT_BITS-1:0] req_operand_a,
   input  logic [PORT_BITS-1:0] req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PORT_BITS-1:0] rsp_result,
   output logic [1:0]           rsp_status
);

   logic [PORT_BITS-1:0] modulus_ff, modulus_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_result_ff, rsp_result_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic        seq_idle;
   logic        accept;
   logic        res_taken;
   item_type    item;
   result_type  seq_res;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // CSR write
   always_comb begin
      modulus_in = csr_write_enable ? csr_write_data : modulus_ff;
   end

   // Intake
   always_comb begin
      req_stall = !seq_idle;
      accept    = req_valid && seq_idle;
      item.mode = req_mode;
      item.a    = req_operand_a[WORD_BITS-1:0];
      item.b    = req_operand_b[WORD_BITS-1:0];
   end

   mmdu_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .item      (item),
      .modulus   (modulus_ff[WORD_BITS-1:0]),
      .idle      (seq_idle),
      .res       (seq_res),
      .res_taken (res_taken),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   mmdu_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Output register: loads when empty or being drained
   always_comb begin
      res_taken     = seq_res.valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      if (res_taken) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = seq_res.result;
         rsp_status_in = seq_res.status;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= PORT_BITS'(MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = PORT_BITS'(rsp_result_ff);
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/core/mmdu_checker.sv =====
// Port-level checks of the modular multiply/divide unit, bound to the top level.
`timescale 1ns / 1ps

module mmdu_checker import mmdu_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [PORT_BITS-1:0] rsp_result,
   input logic [1:0]           rsp_status
);

   // One word at a time: intake closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("word accepted while previous word still in work");

   // Error results carry zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_result == '0))
      else $error("nonzero result with error status");

   // Only defined status codes leave the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_ZERO ||
                     rsp_status == STATUS_NOINV))
      else $error("undefined status code");

   // Stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_result) && $stable(rsp_status)))
      else $error("stalled result word changed");

endmodule

bind modular_multiply_divide_unit mmdu_checker u_mmdu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result),
   .rsp_status (rsp_status)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the modular multiply/divide unit.
`timescale 1ns / 1ps

module testbench;
   import mmdu_pkg::*;

   // Spare mode code; the unit decodes it as a reduction of a
   localparam logic [1:0] MODE_RED_ALT = 2'd3;
   localparam int CYCLE_LIMIT   = 8_000_000;
   localparam int SETTLE_CYCLES = 5000;
   localparam int RANDOM_PHASES = 10;

   typedef struct packed {
      logic [PORT_BITS-1:0] result;
      logic [1:0]           status;
   } answer_type;

   // Predicts each answer from the modulus and keeps them in arrival order
   class mod_scoreboard;
      logic [PORT_BITS-1:0] modulus;
      answer_type answers[$];
      int errors;

      function new();
         modulus = MODULUS_RESET;
         errors  = 0;
      endfunction

      // Extended Euclid: inverse of d modulo m, gcd of d and m through g
      function longint unsigned euclid_inverse(input longint unsigned d,
                                               input longint unsigned m,
                                               output longint unsigned g);
         longint unsigned x, y, cur, prev, q, r, nxt;
         x    = m;
         y    = d;
         cur  = 1;
         prev = 0;
         do begin
            q    = x / y;
            r    = x % y;
            nxt  = ((prev + m) - ((cur * q) % m)) % m;
            x    = y;
            y    = r;
            prev = cur;
            cur  = nxt;
         end while (r != 0);
         g = x;
         return prev % m;
      endfunction

      function answer_type modular_answer(logic [1:0] mode, logic [PORT_BITS-1:0] a_in,
                                          logic [PORT_BITS-1:0] b_in);
         longint unsigned mask, a, b, m, inv, g;
         answer_type ans;
         mask = (64'd1 << WORD_BITS) - 1;
         a = a_in & mask;
         b = b_in & mask;
         m = modulus & mask;
         ans.result = '0;
         ans.status = STATUS_OK;
         if (m == 0) begin
            ans.status = STATUS_ZERO;
         end else begin
            case (mode)
               MODE_MUL: begin
                  ans.result = PORT_BITS'((a * b) % m);
               end
               MODE_DIV: begin
                  if (b == 0) begin
                     ans.status = STATUS_ZERO;
                  end else begin
                     inv = euclid_inverse(b, m, g);
                     if (g != 1) ans.status = STATUS_NOINV;
                     else ans.result = PORT_BITS'((a * inv) % m);
                  end
               end
               default: begin
                  ans.result = PORT_BITS'(a % m);
               end
            endcase
         end
         return ans;
      endfunction

      function void note_word(logic [1:0] mode, logic [PORT_BITS-1:0] a,
                              logic [PORT_BITS-1:0] b);
         answers.push_back(modular_answer(mode, a, b));
      endfunction

      function void check_result(logic [PORT_BITS-1:0] result, logic [1:0] status);
         answer_type want;
         if (answers.size() == 0) begin
            $error("result word with none pending: result %0h status %0d", result, status);
            errors++;
            return;
         end
         want = answers.pop_front();
         if (result !== want.result) begin
            $error("result: expected %0h, got %0h", want.result, result);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [PORT_BITS-1:0] csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_mode;
   logic [PORT_BITS-1:0] req_operand_a;
   logic [PORT_BITS-1:0] req_operand_b;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [PORT_BITS-1:0] rsp_result;
   logic [1:0]           rsp_status;

   mod_scoreboard board;
   bit no_idle = 1'b0;
   int cycle_count = 0;

   modular_multiply_divide_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result       (rsp_result),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stalls at random except during the burst phase
   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 27);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_result, rsp_status);
   end

   // Offer one word; called and returns at a falling edge
   task automatic send_word(logic [1:0] mode, logic [PORT_BITS-1:0] a,
                            logic [PORT_BITS-1:0] b);
      while (!no_idle && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      board.note_word(mode, a, b);
      @(negedge clock);
   endtask

   // Hold off the sender until every pending answer has come back
   task automatic drain_words();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   task automatic write_modulus(logic [PORT_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.modulus = value;
      @(negedge clock);
   endtask

   // Operands lean toward the edges: zero, one, m-1, m, multiples of m, all ones
   function automatic logic [PORT_BITS-1:0] pick_operand(logic [PORT_BITS-1:0] m);
      case ($urandom_range(11))
         0: return '0;
         1: return 1;
         2: return m - 1;
         3: return m;
         4: return m * $urandom_range(2, 9);
         5: return '1;
         6: return $urandom_range(1, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int roll;
      roll = $urandom_range(19);
      if (roll < 7) return MODE_MUL;
      else if (roll < 14) return MODE_DIV;
      else if (roll < 19) return MODE_RED;
      else return MODE_RED_ALT;
   endfunction

   function automatic logic [PORT_BITS-1:0] phase_modulus(int phase);
      case (phase)
         0: return 32'd3;
         1: return 32'hFFFF_FFFB;   // largest 32-bit prime
         2: return $urandom;
         3: return $urandom_range(2, 1000);
         4: return 32'h8000_0000;
         5: return ($urandom | 32'h8000_0000) & 32'hFFFF_FFFE;
         6: return 32'hFFFF_FFFF;
         7: return $urandom_range(2, 65535);
         8: return 32'd0;
         default: return 32'd1;
      endcase
   endfunction

   initial begin
      int words;
      logic [PORT_BITS-1:0] m;
      board            = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_mode         = MODE_MUL;
      req_operand_a    = '0;
      req_operand_b    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: modulus at its reset value
      send_word(MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(MODE_DIV, 32'hFFFF_FFFF, 32'd1);
      send_word(MODE_DIV, 32'd7, 32'd0);
      send_word(MODE_DIV, 32'd7, 32'd2);
      send_word(MODE_RED_ALT, 32'd5, 32'd0);
      drain_words();

      // Prime modulus: divisor above m, multiple of m, m-1
      write_modulus(32'hFFFF_FFFB);
      send_word(MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(MODE_MUL, 32'd0, 32'h1234_5678);
      send_word(MODE_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(MODE_DIV, 32'd7, 32'hFFFF_FFFB);
      send_word(MODE_DIV, 32'd1, 32'hFFFF_FFFA);
      send_word(MODE_RED, 32'hFFFF_FFFB, 32'd0);
      send_word(MODE_RED, 32'hFFFF_FFFA, 32'd0);
      send_word(MODE_RED_ALT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain_words();

      // Largest modulus, composite: shared factors and inverses
      write_modulus(32'hFFFF_FFFF);
      send_word(MODE_DIV, 32'd1, 32'd3);
      send_word(MODE_DIV, 32'hFFFF_FFFE, 32'd2);
      send_word(MODE_DIV, 32'd5, 32'hFFFF_FFFF);
      send_word(MODE_MUL, 32'h8000_0000, 32'd2);
      drain_words();

      // Zero modulus flags every mode
      write_modulus(32'd0);
      send_word(MODE_MUL, 32'd3, 32'd4);
      send_word(MODE_DIV, 32'd3, 32'd4);
      send_word(MODE_RED, 32'd3, 32'd4);
      send_word(MODE_RED_ALT, 32'd3, 32'd4);
      drain_words();

      // Modulus one: all results zero, only a zero divisor flags
      write_modulus(32'd1);
      send_word(MODE_MUL, 32'hFFFF_FFFF, 32'd9);
      send_word(MODE_DIV, 32'd8, 32'd5);
      send_word(MODE_DIV, 32'd8, 32'd0);
      send_word(MODE_RED, 32'hFFFF_FFFF, 32'd0);

      // Random phases, each under its own modulus
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_words();
         m = phase_modulus(phase);
         write_modulus(m);
         no_idle = (phase == 2);
         words   = (phase >= 8) ? 10 : 43;
         for (int k = 0; k < words; k++) begin
            if (k == words / 2) drain_words();
            send_word(pick_mode(), pick_operand(m), pick_operand(m));
         end
      end
      no_idle = 1'b0;
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mmdu_pkg.sv
rtl/core/mmdu_divider.sv
rtl/core/mmdu_sequencer.sv
rtl/core/modular_multiply_divide_unit.sv
rtl/core/mmdu_checker.sv
tb/sv/testbench.sv
